### design/distance_vector_route_update_assert.svh
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_ASSERT_SVH

// same-cycle implication
`define DVRU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DVRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dvru_pkg.sv
package dvru_pkg;

    localparam int NODES   = 16;
    localparam int ID_W    = 4;
    localparam int DIST_W  = 8;
    localparam int MASK_W  = 16;
    localparam int IDX_W   = $clog2(NODES);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // input func codes
    localparam logic [1:0] FUNC_ENTRY  = 2'd0;
    localparam logic [1:0] FUNC_EXPORT = 2'd1;
    localparam logic [1:0] FUNC_INIT   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_COST     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_ROUTE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POISON_DIST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POISON_EN     = 3'd5;

    localparam logic [DIST_W-1:0] DIST_RESET = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        OP_ENTRY,
        OP_EXPORT,
        OP_INIT
    } op_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXPORT
    } bk_state_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [ID_W-1:0]   neighbor_id;
        logic [ID_W-1:0]   dest_id;
        logic [DIST_W-1:0] entry_distance;
        logic              entry_last;
        logic [ID_W-1:0]   receiver_id;
    } in_item_t;

    typedef struct packed {
        logic              error_not_neighbor;
        logic [ID_W-1:0]   out_dest;
        logic [DIST_W-1:0] out_distance;
        logic [ID_W-1:0]   out_next_hop;
        logic              next_hop_valid;
        logic              entry_updated;
        logic              vector_changed;
        logic [MASK_W-1:0] stale_mask;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   self_id;
        logic [MASK_W-1:0] neighbor_mask;
        logic [DIST_W-1:0] link_cost;
        logic [DIST_W-1:0] no_route_distance;
        logic [DIST_W-1:0] poison_distance;
        logic              poison_enable;
    } cfg_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t               op;
        logic              err;
        logic [ID_W-1:0]   nbr;
        logic [ID_W-1:0]   dest;
        logic [DIST_W-1:0] sum;
        logic              last;
        logic [ID_W-1:0]   recv;
    } cmd_t;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
    } hop_t;

endpackage

### design/dvru_front.sv
module dvru_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  dvru_pkg::cfg_t    cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  dvru_pkg::in_item_t s_item,
    output logic              push,
    output dvru_pkg::cmd_t    push_cmd,
    input  logic              q_ready
);

    logic           cmd_valid_reg;
    logic           cmd_valid_next;
    dvru_pkg::cmd_t cmd_reg;
    dvru_pkg::cmd_t cmd_next;
    logic [dvru_pkg::DIST_W:0] raw_sum;
    logic           accept;

    assign s_ready  = !cmd_valid_reg || q_ready;
    assign accept   = s_valid && s_ready;
    assign push     = cmd_valid_reg && q_ready;
    assign push_cmd = cmd_reg;

    assign raw_sum = {1'b0, cfg.link_cost} + {1'b0, s_item.entry_distance};

    always_comb begin
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg && !q_ready;
        if (accept) begin
            cmd_next.err  = !cfg.neighbor_mask[s_item.neighbor_id];
            cmd_next.nbr  = s_item.neighbor_id;
            cmd_next.dest = s_item.dest_id;
            cmd_next.last = s_item.entry_last;
            cmd_next.recv = s_item.receiver_id;
            // saturate at no-route
            if (raw_sum > {1'b0, cfg.no_route_distance}) begin
                cmd_next.sum = cfg.no_route_distance;
            end else begin
                cmd_next.sum = raw_sum[dvru_pkg::DIST_W-1:0];
            end
            cmd_valid_next = 1'b1;
            case (s_item.func)
                dvru_pkg::FUNC_ENTRY:  cmd_next.op = dvru_pkg::OP_ENTRY;
                dvru_pkg::FUNC_EXPORT: cmd_next.op = dvru_pkg::OP_EXPORT;
                dvru_pkg::FUNC_INIT:   cmd_next.op = dvru_pkg::OP_INIT;
                default: begin
                    cmd_next.op    = dvru_pkg::OP_ENTRY;
                    cmd_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
        cmd_reg <= cmd_next;
    end

endmodule

### design/dvru_queue.sv
module dvru_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dvru_pkg::cmd_t push_cmd,
    output logic           q_ready,
    output logic           q_valid,
    output dvru_pkg::cmd_t q_cmd,
    input  logic           pop
);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    dvru_pkg::cmd_t    mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign q_ready = cnt_reg != QCNT_W'(QDEPTH);
    assign q_valid = cnt_reg != '0;
    assign q_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### design/dvru_back.sv
module dvru_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  dvru_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  dvru_pkg::cmd_t      q_cmd,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output dvru_pkg::out_item_t m_item
);

    dvru_pkg::bk_state_t state_reg;
    dvru_pkg::bk_state_t state_next;

    logic [dvru_pkg::DIST_W-1:0] dist_reg  [dvru_pkg::NODES];
    logic [dvru_pkg::DIST_W-1:0] dist_next [dvru_pkg::NODES];
    dvru_pkg::hop_t              hop_reg   [dvru_pkg::NODES];
    dvru_pkg::hop_t              hop_next  [dvru_pkg::NODES];

    logic                          flag_reg;
    logic                          flag_next;
    logic [dvru_pkg::MASK_W-1:0]   stale_reg;
    logic [dvru_pkg::MASK_W-1:0]   stale_next;
    logic [dvru_pkg::IDX_W-1:0]    cnt_reg;
    logic [dvru_pkg::IDX_W-1:0]    cnt_next;
    logic [dvru_pkg::ID_W-1:0]     recv_reg;
    logic [dvru_pkg::ID_W-1:0]     recv_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    dvru_pkg::out_item_t           out_reg;
    dvru_pkg::out_item_t           out_next;

    logic                          out_free;
    logic [dvru_pkg::DIST_W-1:0]   old_dist;
    dvru_pkg::hop_t                old_hop;
    logic                          upd;
    logic [dvru_pkg::DIST_W-1:0]   relax_dist;
    dvru_pkg::hop_t                new_hop;
    logic [dvru_pkg::MASK_W-1:0]   stale_upd;
    dvru_pkg::hop_t                exp_hop;
    logic                          self_nbr;

    assign m_valid  = out_valid_reg;
    assign m_item   = out_reg;
    assign out_free = !out_valid_reg || m_ready;

    assign old_dist   = dist_reg[q_cmd.dest];
    assign old_hop    = hop_reg[q_cmd.dest];
    assign upd        = !q_cmd.err && (q_cmd.sum < old_dist);
    assign relax_dist = upd ? q_cmd.sum : old_dist;
    assign new_hop    = upd ? dvru_pkg::hop_t'{valid: 1'b1, id: q_cmd.nbr} : old_hop;
    assign stale_upd  = upd ? (stale_reg | cfg.neighbor_mask) : stale_reg;
    assign exp_hop    = hop_reg[cnt_reg];
    assign self_nbr   = cfg.neighbor_mask[cfg.self_id];

    always_comb begin
        state_next     = state_reg;
        dist_next      = dist_reg;
        hop_next       = hop_reg;
        flag_next      = flag_reg;
        stale_next     = stale_reg;
        cnt_next       = cnt_reg;
        recv_next      = recv_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        pop            = 1'b0;
        case (state_reg)
            dvru_pkg::BK_IDLE: begin
                if (q_valid && out_free) begin
                    pop = 1'b1;
                    case (q_cmd.op)
                        dvru_pkg::OP_ENTRY: begin
                            dist_next[q_cmd.dest] = relax_dist;
                            hop_next[q_cmd.dest]  = new_hop;
                            stale_next = stale_upd;
                            flag_next  = q_cmd.last ? 1'b0 : (flag_reg | upd);
                            out_next.error_not_neighbor = q_cmd.err;
                            out_next.out_dest       = q_cmd.dest;
                            out_next.out_distance   = relax_dist;
                            out_next.out_next_hop   = new_hop.valid ? new_hop.id : '0;
                            out_next.next_hop_valid = new_hop.valid;
                            out_next.entry_updated  = upd;
                            out_next.vector_changed = q_cmd.last & (flag_reg | upd);
                            out_next.stale_mask     = stale_upd;
                            out_next.last           = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        dvru_pkg::OP_INIT: begin
                            for (int i = 0; i < dvru_pkg::NODES; i++) begin
                                if (cfg.neighbor_mask[i]) begin
                                    dist_next[i] = cfg.link_cost;
                                    hop_next[i]  = '{valid: 1'b1,
                                                     id: dvru_pkg::ID_W'(i)};
                                end else begin
                                    dist_next[i] = cfg.no_route_distance;
                                    hop_next[i]  = '{valid: 1'b0, id: '0};
                                end
                            end
                            dist_next[cfg.self_id] = '0;
                            stale_next = cfg.neighbor_mask;
                            flag_next  = 1'b0;
                            out_next.error_not_neighbor = 1'b0;
                            out_next.out_dest       = cfg.self_id;
                            out_next.out_distance   = '0;
                            out_next.out_next_hop   = self_nbr ? cfg.self_id : '0;
                            out_next.next_hop_valid = self_nbr;
                            out_next.entry_updated  = 1'b0;
                            out_next.vector_changed = 1'b0;
                            out_next.stale_mask     = cfg.neighbor_mask;
                            out_next.last           = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        dvru_pkg::OP_EXPORT: begin
                            stale_next[q_cmd.recv] = 1'b0;
                            recv_next  = q_cmd.recv;
                            cnt_next   = '0;
                            state_next = dvru_pkg::BK_EXPORT;
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            dvru_pkg::BK_EXPORT: begin
                if (out_free) begin
                    out_next.error_not_neighbor = 1'b0;
                    out_next.out_dest       = dvru_pkg::ID_W'(cnt_reg);
                    // poisoned reverse
                    if (cfg.poison_enable && exp_hop.valid && exp_hop.id == recv_reg) begin
                        out_next.out_distance = cfg.poison_distance;
                    end else begin
                        out_next.out_distance = dist_reg[cnt_reg];
                    end
                    out_next.out_next_hop   = exp_hop.valid ? exp_hop.id : '0;
                    out_next.next_hop_valid = exp_hop.valid;
                    out_next.entry_updated  = 1'b0;
                    out_next.vector_changed = 1'b0;
                    out_next.stale_mask     = stale_reg;
                    out_next.last = cnt_reg == dvru_pkg::IDX_W'(dvru_pkg::NODES - 1);
                    out_valid_next = 1'b1;
                    cnt_next = cnt_reg + dvru_pkg::IDX_W'(1);
                    if (cnt_reg == dvru_pkg::IDX_W'(dvru_pkg::NODES - 1)) begin
                        state_next = dvru_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = dvru_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dvru_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < dvru_pkg::NODES; i++) begin
                dist_reg[i] <= dvru_pkg::DIST_RESET;
                hop_reg[i]  <= '{valid: 1'b0, id: '0};
            end
            flag_reg      <= 1'b0;
            stale_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            dist_reg      <= dist_next;
            hop_reg       <= hop_next;
            flag_reg      <= flag_next;
            stale_reg     <= stale_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
        recv_reg <= recv_next;
        out_reg  <= out_next;
    end

endmodule

### design/distance_vector_route_update.sv
// Path: an accepted input goes through the front reg, the queue and the output reg to its result.
// Throughput: entry/init items 1 per cycle, 1 result each, while m_ready is high and no export runs.
// Export items: a setup step in the back, then one result per cycle while m_ready holds, NODES in all.
// Reset (aresetn low, synchronous): tables to all no-route 255 with invalid hops, stale and
// changed flags cleared, queue emptied, configuration to its defaults. No clearing pass.
`include "distance_vector_route_update_assert.svh"

module distance_vector_route_update (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dvru_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dvru_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  dvru_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output dvru_pkg::out_item_t                 m_item
);

    dvru_pkg::cfg_t cfg_reg;
    dvru_pkg::cfg_t cfg_next;
    logic           push;
    dvru_pkg::cmd_t push_cmd;
    logic           q_ready;
    logic           q_valid;
    dvru_pkg::cmd_t q_cmd;
    logic           pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                dvru_pkg::CFG_SELF_ID:
                    cfg_next.self_id = cfg_wdata[dvru_pkg::ID_W-1:0];
                dvru_pkg::CFG_NEIGHBOR_MASK:
                    cfg_next.neighbor_mask = cfg_wdata[dvru_pkg::MASK_W-1:0];
                dvru_pkg::CFG_LINK_COST:
                    cfg_next.link_cost = cfg_wdata[dvru_pkg::DIST_W-1:0];
                dvru_pkg::CFG_NO_ROUTE:
                    cfg_next.no_route_distance = cfg_wdata[dvru_pkg::DIST_W-1:0];
                dvru_pkg::CFG_POISON_DIST:
                    cfg_next.poison_distance = cfg_wdata[dvru_pkg::DIST_W-1:0];
                dvru_pkg::CFG_POISON_EN:
                    cfg_next.poison_enable = cfg_wdata[0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.self_id           <= '0;
            cfg_reg.neighbor_mask     <= '0;
            cfg_reg.link_cost         <= dvru_pkg::DIST_W'(1);
            cfg_reg.no_route_distance <= dvru_pkg::DIST_RESET;
            cfg_reg.poison_distance   <= dvru_pkg::DIST_RESET;
            cfg_reg.poison_enable     <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    dvru_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready)
    );

    dvru_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop)
    );

    dvru_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    `DVRU_ASSERT_NOW(a_push_room, push, q_ready, "front pushed into a full queue")
    `DVRU_ASSERT_NOW(a_pop_valid, pop, q_valid, "back popped an empty queue")
    `DVRU_ASSERT_NEXT(a_export_stream, m_valid && !m_item.last, m_valid, "export stream broke")
    `DVRU_ASSERT_NOW(a_upd_hop, m_valid && m_item.entry_updated,
        m_item.next_hop_valid && !m_item.error_not_neighbor, "update without valid hop")

endmodule
